/* src/ledenc_pkg.sv */
// Package for the addressable LED pulse encoder: widths, register indexes,
// phase codes, opcodes and register reset values. No dependencies.
`default_nettype none

package ledenc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int CNT_W      = 10;
    localparam int LATCH_W    = 20;
    localparam int BYTE_W     = 8;
    localparam int BITIDX_W   = 4;
    localparam int OUT_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_LOW  = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SEND  = 2'd1;
    localparam logic [1:0] PH_LATCH = 2'd2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_OFFER = 1'b1;

    localparam logic [CNT_W-1:0]   RST_ZERO_HIGH  = 10'd35;
    localparam logic [CNT_W-1:0]   RST_ONE_HIGH   = 10'd90;
    localparam logic [CNT_W-1:0]   RST_BIT_PERIOD = 10'd125;
    localparam logic [LATCH_W-1:0] RST_LATCH_LOW  = 20'd30000;

endpackage

`default_nettype wire

/* src/addressable_led_pulse_encoder_top.sv */
// Addressable LED pulse encoder, top level; single module.
// Depends on ledenc_pkg.
// Each taken input word yields one result word in the output register.
// Throughput: one word per cycle; s_tready is high whenever the output register
// is empty or being taken. Reset (aresetn low, synchronous) returns timing
// registers to their defaults, the line state to idle and empties the output.
`default_nettype none

module addressable_led_pulse_encoder_top (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    input  wire  [ledenc_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] data_byte
    input  wire                                    s_tuser,   // [0] opcode
    input  wire                                    s_tlast,   // last_byte
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    // [0] line_level, [1] byte_taken, [2] buffer_free, [3] busy_res,
    // [4] underrun, [5] frame_done, [7:6] zero
    output logic [ledenc_pkg::OUT_W-1:0]           m_tdata,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [ledenc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [ledenc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ledenc_pkg::*;

    logic [CNT_W-1:0]    zero_high_reg, one_high_reg, bit_period_reg;
    logic [LATCH_W-1:0]  latch_low_reg;

    logic [BYTE_W-1:0]   shift_byte_reg, shift_byte_next;
    logic                shift_last_reg, shift_last_next;
    logic [BITIDX_W-1:0] bit_index_reg, bit_index_next;
    logic [CNT_W-1:0]    cycle_count_reg, cycle_count_next;
    logic [BYTE_W-1:0]   held_byte_reg, held_byte_next;
    logic                held_last_reg, held_last_next;
    logic                held_valid_reg, held_valid_next;
    logic [LATCH_W-1:0]  latch_count_reg, latch_count_next;
    logic [1:0]          phase_reg, phase_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    logic                accept;
    logic                line, taken, busy, under, done;
    logic                cur_bit;
    logic [CNT_W-1:0]    high_cnt;
    logic [CNT_W-1:0]    cyc_inc;
    logic [BITIDX_W-1:0] idx_inc;
    logic [LATCH_W:0]    latch_inc;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_high_reg  <= RST_ZERO_HIGH;
            one_high_reg   <= RST_ONE_HIGH;
            bit_period_reg <= RST_BIT_PERIOD;
            latch_low_reg  <= RST_LATCH_LOW;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ZERO_HIGH:  zero_high_reg  <= cfg_data[CNT_W-1:0];
                REG_ONE_HIGH:   one_high_reg   <= cfg_data[CNT_W-1:0];
                REG_BIT_PERIOD: bit_period_reg <= cfg_data[CNT_W-1:0];
                REG_LATCH_LOW:  latch_low_reg  <= cfg_data[LATCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        shift_byte_next  = shift_byte_reg;
        shift_last_next  = shift_last_reg;
        bit_index_next   = bit_index_reg;
        cycle_count_next = cycle_count_reg;
        held_byte_next   = held_byte_reg;
        held_last_next   = held_last_reg;
        held_valid_next  = held_valid_reg;
        latch_count_next = latch_count_reg;
        phase_next       = phase_reg;
        line  = 1'b0;
        taken = 1'b0;
        busy  = 1'b0;
        under = 1'b0;
        done  = 1'b0;
        cur_bit   = 1'b0;
        high_cnt  = '0;
        cyc_inc   = '0;
        idx_inc   = '0;
        latch_inc = '0;

        if (s_tuser == OP_OFFER) begin
            if (!held_valid_reg) begin
                held_byte_next  = s_tdata;
                held_last_next  = s_tlast;
                held_valid_next = 1'b1;
                taken           = 1'b1;
            end
            busy = (phase_reg == PH_SEND) || (phase_reg == PH_LATCH);
        end else begin
            if (phase_reg == PH_SEND) begin
                cur_bit  = shift_byte_reg[3'd7 - bit_index_reg[2:0]];
                high_cnt = cur_bit ? one_high_reg : zero_high_reg;
                busy     = 1'b1;
                line     = cycle_count_reg < high_cnt;
                cyc_inc  = cycle_count_reg + 1'b1;
                cycle_count_next = cyc_inc;
                if (cyc_inc >= bit_period_reg) begin
                    cycle_count_next = '0;
                    idx_inc          = bit_index_reg + 1'b1;
                    bit_index_next   = idx_inc;
                    if (idx_inc >= BITIDX_W'(BYTE_W)) begin
                        bit_index_next = '0;
                        if (shift_last_reg) begin
                            phase_next       = PH_LATCH;
                            latch_count_next = '0;
                        end else if (held_valid_reg) begin
                            shift_byte_next = held_byte_reg;
                            shift_last_next = held_last_reg;
                            held_valid_next = 1'b0;
                            phase_next      = PH_SEND;
                        end else begin
                            under      = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end else if (phase_reg == PH_LATCH) begin
                busy      = 1'b1;
                latch_inc = {1'b0, latch_count_reg} + 1'b1;
                if (latch_inc >= {1'b0, latch_low_reg}) begin
                    latch_count_next = '0;
                    done             = 1'b1;
                    phase_next       = PH_IDLE;
                end else begin
                    latch_count_next = latch_inc[LATCH_W-1:0];
                end
            end else begin
                phase_next = PH_IDLE;
                if (held_valid_reg) begin
                    // load and drive the first tick of bit 7 at once
                    shift_byte_next = held_byte_reg;
                    shift_last_next = held_last_reg;
                    held_valid_next = 1'b0;
                    bit_index_next  = '0;
                    phase_next      = PH_SEND;
                    cur_bit         = held_byte_reg[BYTE_W-1];
                    high_cnt        = cur_bit ? one_high_reg : zero_high_reg;
                    busy            = 1'b1;
                    line            = high_cnt != '0;
                    cycle_count_next = CNT_W'(1);
                    if (CNT_W'(1) >= bit_period_reg) begin
                        cycle_count_next = '0;
                        bit_index_next   = BITIDX_W'(1);
                    end
                end
            end
        end

        m_tdata_next = {2'b00, done, under, busy, !held_valid_next, taken, line};
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_byte_reg  <= '0;
            shift_last_reg  <= 1'b0;
            bit_index_reg   <= '0;
            cycle_count_reg <= '0;
            held_byte_reg   <= '0;
            held_last_reg   <= 1'b0;
            held_valid_reg  <= 1'b0;
            latch_count_reg <= '0;
            phase_reg       <= PH_IDLE;
            m_tvalid_reg    <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                shift_byte_reg  <= shift_byte_next;
                shift_last_reg  <= shift_last_next;
                bit_index_reg   <= bit_index_next;
                cycle_count_reg <= cycle_count_next;
                held_byte_reg   <= held_byte_next;
                held_last_reg   <= held_last_next;
                held_valid_reg  <= held_valid_next;
                latch_count_reg <= latch_count_next;
                phase_reg       <= phase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire
